// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file ssp_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ===== rtl/core/ssp_pkg.sv =====
`default_nettype none
package ssp_pkg;

	localparam int SLOTS = 4;

	localparam logic [16:0] NO_TIME = 17'd86401;

	localparam logic [2:0] KIND_ADD    = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_MODIFY = 3'd2;
	localparam logic [2:0] KIND_RENAME = 3'd3;
	localparam logic [2:0] KIND_LOOKUP = 3'd4;
	localparam logic [2:0] KIND_VICTIM = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  room_id;
		logic [7:0]  new_room_id;
		logic [1:0]  fan_speed;
		logic [16:0] start_time;
	} req_item_t;

	typedef struct packed {
		logic        op_ok;
		logic [7:0]  result_room;
		logic [1:0]  result_speed;
		logic [16:0] result_start;
		logic [2:0]  entry_count;
	} rsp_item_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  room;
		logic [1:0]  speed;
		logic [16:0] start;
	} slot_t;

	typedef struct packed {
		req_item_t   op;
		logic        done;
		logic        ok;
		logic [1:0]  best_speed;
		logic [16:0] best_start;
		logic [7:0]  pick_room;
		logic [1:0]  pick_speed;
		logic [16:0] pick_start;
		logic [2:0]  count;
	} scan_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssp_cell.sv =====
`default_nettype none
module ssp_cell (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               rec_in_valid,
	input  ssp_pkg::scan_rec_t rec_in,
	input  ssp_pkg::slot_t    next_slot,
	output ssp_pkg::slot_t    slot,
	output logic              rec_out_valid,
	output ssp_pkg::scan_rec_t rec_out
);
	import ssp_pkg::*;

	logic        valid_q;
	logic [7:0]  room_q;
	logic [1:0]  speed_q;
	logic [16:0] start_q;
	slot_t       cur;
	slot_t       nxt;
	scan_rec_t   rec_nxt;
	logic        hit;
	logic        better;

	assign cur  = '{valid: valid_q, room: room_q, speed: speed_q, start: start_q};
	assign slot = cur;

	always_comb begin
		nxt     = cur;
		rec_nxt = rec_in;
		hit     = valid_q && (room_q == rec_in.op.room_id) && !rec_in.done;
		better  = valid_q && ((speed_q < rec_in.best_speed) ||
			((speed_q == rec_in.best_speed) && (start_q < rec_in.best_start)));
		case (rec_in.op.kind)
			KIND_ADD: begin
				if (!valid_q && !rec_in.done) begin
					nxt          = '{valid: 1'b1, room: rec_in.op.room_id,
						speed: rec_in.op.fan_speed, start: rec_in.op.start_time};
					rec_nxt.done = 1'b1;
					rec_nxt.ok   = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (rec_in.done) begin
					nxt = next_slot;
				end else if (hit) begin
					nxt                = next_slot;
					rec_nxt.done       = 1'b1;
					rec_nxt.ok         = 1'b1;
					rec_nxt.pick_room  = room_q;
					rec_nxt.pick_speed = speed_q;
					rec_nxt.pick_start = start_q;
				end
			end
			KIND_MODIFY: begin
				if (hit) begin
					nxt.speed    = rec_in.op.fan_speed;
					nxt.start    = rec_in.op.start_time;
					rec_nxt.done = 1'b1;
					rec_nxt.ok   = 1'b1;
				end
			end
			KIND_RENAME: begin
				if (hit) begin
					nxt.room     = rec_in.op.new_room_id;
					nxt.speed    = rec_in.op.fan_speed;
					nxt.start    = rec_in.op.start_time;
					rec_nxt.done = 1'b1;
					rec_nxt.ok   = 1'b1;
				end
			end
			KIND_LOOKUP: begin
				if (hit) begin
					rec_nxt.done       = 1'b1;
					rec_nxt.ok         = 1'b1;
					rec_nxt.pick_speed = speed_q;
				end
			end
			KIND_VICTIM: begin
				if (better) begin
					rec_nxt.ok         = 1'b1;
					rec_nxt.best_speed = speed_q;
					rec_nxt.best_start = start_q;
					rec_nxt.pick_room  = room_q;
					rec_nxt.pick_speed = speed_q;
					rec_nxt.pick_start = start_q;
				end
			end
			default: begin
			end
		endcase
		rec_nxt.count = rec_in.count + {2'b00, nxt.valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			rec_out_valid <= 1'b0;
		end else begin
			rec_out_valid <= rec_in_valid;
			if (rec_in_valid) begin
				valid_q <= nxt.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_in_valid) begin
			room_q  <= nxt.room;
			speed_q <= nxt.speed;
			start_q <= nxt.start;
			rec_out <= rec_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/service_slot_priority_table_top.sv =====
// Service slot table with priority-based victim selection.
// Request channel req_valid/req_ready/req carries one operation item: add,
// remove by id, modify, rename, priority lookup or victim select. Response
// channel rsp_valid/rsp_ready/rsp returns exactly one item per request.
// The slots sit in a chain of SLOTS cells; an accepted item travels through
// the chain one cell per cycle, each cell updating its own slot on the way
// (remove pulls each later slot one place forward from its right neighbor).
// The response is registered in the output register once the item leaves
// the last cell. A new request is taken only after the item has left the
// chain; only one item is in the chain at a time.
// Stall: a finished item waits in the output register; the next request is
// still taken, and its response parks in a one-entry skid register. Further
// requests wait until that skid entry drains.
// Reset: all slots empty, no item in flight, rsp_valid low.
`default_nettype none
module service_slot_priority_table_top (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  ssp_pkg::req_item_t req,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output ssp_pkg::rsp_item_t rsp
);
	import ssp_pkg::*;

	logic      rec_v [SLOTS+1];
	scan_rec_t rec   [SLOTS+1];
	slot_t     slot_w [SLOTS+1];

	logic      busy_q;
	logic      skid_v_q;
	rsp_item_t skid_q;
	rsp_item_t rsp_q;
	logic      rsp_v_q;
	rsp_item_t fin;
	logic      take;

	assign req_ready = !busy_q && !skid_v_q;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;
	assign take      = rsp_v_q && rsp_ready;

	assign rec_v[0]     = req_valid && req_ready;
	assign rec[0]       = '{op: req, done: 1'b0, ok: 1'b0, best_speed: req.fan_speed,
		best_start: NO_TIME, pick_room: '0, pick_speed: '0, pick_start: '0, count: '0};
	assign slot_w[SLOTS] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ssp_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.rec_in_valid (rec_v[i]),
			.rec_in       (rec[i]),
			.next_slot    (slot_w[i+1]),
			.slot         (slot_w[i]),
			.rec_out_valid(rec_v[i+1]),
			.rec_out      (rec[i+1])
		);
	end

	assign fin = '{op_ok: rec[SLOTS].ok, result_room: rec[SLOTS].pick_room,
		result_speed: rec[SLOTS].pick_speed, result_start: rec[SLOTS].pick_start,
		entry_count: rec[SLOTS].count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			skid_v_q <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			if (rec_v[0]) begin
				busy_q <= 1'b1;
			end else if (rec_v[SLOTS]) begin
				busy_q <= 1'b0;
			end
			if (skid_v_q) begin
				if (take) begin
					skid_v_q <= 1'b0;
				end
			end else if (rec_v[SLOTS]) begin
				if (rsp_v_q && !rsp_ready) begin
					skid_v_q <= 1'b1;
				end else begin
					rsp_v_q <= 1'b1;
				end
			end else if (take) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				rsp_q <= skid_q;
			end
		end else if (rec_v[SLOTS]) begin
			if (rsp_v_q && !rsp_ready) begin
				skid_q <= fin;
			end else begin
				rsp_q <= fin;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ssp_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module ssp_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               req_valid,
	input wire               req_ready,
	input wire               rsp_valid,
	input wire               rsp_ready,
	input ssp_pkg::rsp_item_t rsp
);
	import ssp_pkg::*;

	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`CHK_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	`CHK_SAME(a_count_max, rsp_valid, rsp.entry_count <= 3'(SLOTS))
	`CHK_SAME(a_fail_zero, rsp_valid && !rsp.op_ok, (rsp.result_room == 8'd0) && (rsp.result_speed == 2'd0) && (rsp.result_start == 17'd0))

endmodule

bind service_slot_priority_table_top ssp_chk u_ssp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import ssp_pkg::*;

	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_PER_PHASE = 550;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_item_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_item_t rsp;

	service_slot_priority_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	logic [7:0] tbl_room [SLOTS];
	logic [1:0] tbl_speed [SLOTS];
	logic [16:0] tbl_start [SLOTS];
	int tbl_used = 0;

	req_item_t op_backlog [$];
	rsp_item_t table_answers_q [$];
	rsp_item_t answer_due;
	int ops_queued = 0;
	int ops_taken = 0;
	int mismatch_cnt = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic req_fire = 1'b0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic rsp_item_t table_apply(input req_item_t r);
		rsp_item_t o;
		int hit;
		logic [1:0] bs;
		logic [16:0] bt;
		o = '0;
		hit = -1;
		for (int i = tbl_used - 1; i >= 0; i--)
			if (tbl_room[i] == r.room_id)
				hit = i;
		case (r.kind)
			KIND_ADD: begin
				if (tbl_used < SLOTS) begin
					tbl_room[tbl_used] = r.room_id;
					tbl_speed[tbl_used] = r.fan_speed;
					tbl_start[tbl_used] = r.start_time;
					tbl_used++;
					o.op_ok = 1'b1;
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					o.op_ok = 1'b1;
					o.result_room = tbl_room[hit];
					o.result_speed = tbl_speed[hit];
					o.result_start = tbl_start[hit];
					for (int i = hit; i < tbl_used - 1; i++) begin
						tbl_room[i] = tbl_room[i + 1];
						tbl_speed[i] = tbl_speed[i + 1];
						tbl_start[i] = tbl_start[i + 1];
					end
					tbl_used--;
				end
			end
			KIND_MODIFY: begin
				if (hit >= 0) begin
					o.op_ok = 1'b1;
					tbl_speed[hit] = r.fan_speed;
					tbl_start[hit] = r.start_time;
				end
			end
			KIND_RENAME: begin
				if (hit >= 0) begin
					o.op_ok = 1'b1;
					tbl_room[hit] = r.new_room_id;
					tbl_speed[hit] = r.fan_speed;
					tbl_start[hit] = r.start_time;
				end
			end
			KIND_LOOKUP: begin
				if (hit >= 0) begin
					o.op_ok = 1'b1;
					o.result_speed = tbl_speed[hit];
				end
			end
			KIND_VICTIM: begin
				bs = r.fan_speed;
				bt = NO_TIME;
				for (int i = 0; i < tbl_used; i++) begin
					if (tbl_speed[i] < bs || (tbl_speed[i] == bs && tbl_start[i] < bt)) begin
						o.op_ok = 1'b1;
						bs = tbl_speed[i];
						bt = tbl_start[i];
						o.result_room = tbl_room[i];
						o.result_speed = tbl_speed[i];
						o.result_start = tbl_start[i];
					end
				end
			end
			default: begin
			end
		endcase
		o.entry_count = 3'(tbl_used);
		return o;
	endfunction

	function automatic req_item_t mk_op(input logic [2:0] k, input logic [7:0] id,
			input logic [7:0] nid, input logic [1:0] spd, input logic [16:0] st);
		req_item_t r;
		r.kind = k;
		r.room_id = id;
		r.new_room_id = nid;
		r.fan_speed = spd;
		r.start_time = st;
		return r;
	endfunction

	function automatic logic [7:0] pick_room();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom);
			default: return 8'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [16:0] pick_start();
		case ($urandom_range(0, 19))
			0: begin
				case ($urandom_range(0, 4))
					0: return 17'd0;
					1: return 17'd86399;
					2: return 17'd86400;
					3: return NO_TIME;
					default: return 17'd86402;
				endcase
			end
			1: return 17'($urandom);
			default: return 17'($urandom_range(0, 86399));
		endcase
	endfunction

	function automatic req_item_t random_op();
		req_item_t r;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			r.kind = KIND_ADD;
		else if (roll < 48)
			r.kind = KIND_REMOVE;
		else if (roll < 60)
			r.kind = KIND_MODIFY;
		else if (roll < 72)
			r.kind = KIND_RENAME;
		else if (roll < 82)
			r.kind = KIND_LOOKUP;
		else if (roll < 96)
			r.kind = KIND_VICTIM;
		else
			r.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_A : KIND_SPARE_B;
		r.room_id = pick_room();
		r.new_room_id = pick_room();
		r.fan_speed = 2'($urandom);
		r.start_time = pick_start();
		return r;
	endfunction

	task automatic queue_op(input req_item_t r);
		op_backlog.push_back(r);
		ops_queued++;
	endtask

	task automatic queue_directed();
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd3, 17'd0));
		queue_op(mk_op(KIND_ADD, 8'd0, 8'd255, 2'd3, 17'd0));
		queue_op(mk_op(KIND_ADD, 8'd255, 8'd0, 2'd0, 17'd86399));
		queue_op(mk_op(KIND_ADD, 8'd7, 8'd0, 2'd1, 17'd100));
		queue_op(mk_op(KIND_ADD, 8'd7, 8'd0, 2'd1, 17'd50));
		queue_op(mk_op(KIND_ADD, 8'd9, 8'd0, 2'd2, 17'd1));
		queue_op(mk_op(KIND_LOOKUP, 8'd7, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_LOOKUP, 8'd200, 8'd0, 2'd3, 17'd0));
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd3, 17'd0));
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_MODIFY, 8'd255, 8'd0, 2'd2, NO_TIME));
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd2, 17'd0));
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_REMOVE, 8'd0, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_REMOVE, 8'd200, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_RENAME, 8'd7, 8'd8, 2'd2, 17'd86402));
		queue_op(mk_op(KIND_RENAME, 8'd100, 8'd255, 2'd1, 17'd5));
		queue_op(mk_op(KIND_MODIFY, 8'd7, 8'd0, 2'd2, 17'h1FFFF));
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd2, 17'd0));
		queue_op(mk_op(KIND_VICTIM, 8'd0, 8'd0, 2'd3, 17'd0));
		queue_op(mk_op(KIND_SPARE_A, 8'd255, 8'd255, 2'd3, 17'h1FFFF));
		queue_op(mk_op(KIND_SPARE_B, 8'd7, 8'd8, 2'd1, 17'd86399));
		queue_op(mk_op(KIND_REMOVE, 8'd7, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_REMOVE, 8'd8, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_REMOVE, 8'd255, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_REMOVE, 8'd255, 8'd0, 2'd0, 17'd0));
		queue_op(mk_op(KIND_LOOKUP, 8'd0, 8'd0, 2'd0, 17'd0));
	endtask

	// drive on the falling edge, hold until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_ready <= 1'b0;
		end else begin
			if (!req_valid || req_fire) begin
				if (op_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req <= op_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (table_answers_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("unexpected item: ok=%0d room=%0d speed=%0d start=%0d count=%0d",
							rsp.op_ok, rsp.result_room, rsp.result_speed,
							rsp.result_start, rsp.entry_count);
					mismatch_cnt++;
				end else begin
					answer_due = table_answers_q.pop_front();
					if (rsp !== answer_due) begin
						if (mismatch_cnt < 10)
							$display({"mismatch: exp ok=%0d room=%0d speed=%0d start=%0d count=%0d",
								" got ok=%0d room=%0d speed=%0d start=%0d count=%0d"},
								answer_due.op_ok, answer_due.result_room,
								answer_due.result_speed, answer_due.result_start,
								answer_due.entry_count, rsp.op_ok, rsp.result_room,
								rsp.result_speed, rsp.result_start, rsp.entry_count);
						mismatch_cnt++;
					end
				end
			end
			if (req_valid && req_ready) begin
				table_answers_q.push_back(table_apply(req));
				ops_taken <= ops_taken + 1;
			end
			req_fire <= req_valid && req_ready;
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_ready = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			@(posedge clk);
			case (ph)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (ph == 0)
				queue_directed();
			repeat (RANDOM_PER_PHASE) queue_op(random_op());
			do
				@(negedge clk);
			while (!(ops_taken == ops_queued && table_answers_q.size() == 0));
		end
		repeat (4 * (SLOTS + 2)) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
